// ===== src/udiv_pkg.sv =====
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared width constant and the pipeline stage record of the unsigned divider.
// ----------------------------------------------------------------------------
package udiv_pkg;

   localparam int DATA_WIDTH = 32;

   // Restoring division retires one quotient bit per stage.
   localparam int NUM_STAGES = DATA_WIDTH;

   typedef logic [DATA_WIDTH-1:0] word_type;

   // Contents of one pipeline stage. The high bits of dq hold dividend bits
   // still to be consumed, and quotient bits shift in from the bottom.
   typedef struct packed {
      logic     valid;
      logic     div_zero;
      word_type rem;
      word_type dq;
      word_type divisor;
   } stage_type;

endpackage

// ===== src/udiv_stage.sv =====
// ----------------------------------------------------------------------------
// udiv_stage
// One restoring shift-and-subtract step with its pipeline register.
// ----------------------------------------------------------------------------
module udiv_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  udiv_pkg::stage_type  stage_i,
   output udiv_pkg::stage_type  stage_o
);

   logic [udiv_pkg::DATA_WIDTH:0]   trial;
   logic [udiv_pkg::DATA_WIDTH+1:0] diff;
   logic                            fits;
   udiv_pkg::stage_type             stage_in;
   logic                            valid_ff;
   udiv_pkg::stage_type             data_ff;

   always_comb begin
      // Bring down the next dividend bit and try the divisor against it.
      trial = {stage_i.rem, stage_i.dq[udiv_pkg::DATA_WIDTH-1]};
      diff  = {1'b0, trial} - {2'b00, stage_i.divisor};
      fits  = ~diff[udiv_pkg::DATA_WIDTH+1];

      stage_in          = stage_i;
      stage_in.rem      = fits ? diff[udiv_pkg::DATA_WIDTH-1:0]
                               : trial[udiv_pkg::DATA_WIDTH-1:0];
      stage_in.dq       = {stage_i.dq[udiv_pkg::DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= stage_in;
      end
   end

   always_comb begin
      stage_o       = data_ff;
      stage_o.valid = valid_ff;
   end

endmodule

// ===== src/unsigned_divider_32_unit.sv =====
// ----------------------------------------------------------------------------
// unsigned_divider_32_unit
// Pipelined 32-bit unsigned divider returning quotient and remainder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: dividend and divisor, taken on a clock edge where
//   req_valid is high and req_stall is low.
//   Result channel rsp_*: quotient, remainder and divide_by_zero, handed over
//   on an edge where rsp_valid is high and rsp_stall is low.
//   The datapath is 32 restoring stages, one quotient bit each, followed by
//   an output register. A new transaction may enter every cycle while
//   req_stall is low.
//   A zero divisor sets divide_by_zero and returns all ones in both quotient
//   and remainder.
//   Reset (synchronous, active high) empties the pipeline; no results are
//   pending afterwards.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module unsigned_divider_32_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [udiv_pkg::DATA_WIDTH-1:0]    req_dividend,
   input  logic [udiv_pkg::DATA_WIDTH-1:0]    req_divisor,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [udiv_pkg::DATA_WIDTH-1:0]    rsp_quotient,
   output logic [udiv_pkg::DATA_WIDTH-1:0]    rsp_remainder,
   output logic                               rsp_divide_by_zero
);

   udiv_pkg::stage_type                 pipe [0:udiv_pkg::NUM_STAGES];
   udiv_pkg::stage_type                 head_stage;
   logic                                advance;
   logic                                rsp_valid_ff;
   logic [udiv_pkg::DATA_WIDTH-1:0]     quotient_ff;
   logic [udiv_pkg::DATA_WIDTH-1:0]     quotient_in;
   logic [udiv_pkg::DATA_WIDTH-1:0]     remainder_ff;
   logic [udiv_pkg::DATA_WIDTH-1:0]     remainder_in;
   logic                                dbz_ff;

   // Pipeline moves as a whole unless a finished result is being held.
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~advance;

   always_comb begin
      head_stage.valid    = req_valid;
      head_stage.div_zero = (req_divisor == '0);
      head_stage.rem      = '0;
      head_stage.dq       = req_dividend;
      head_stage.divisor  = req_divisor;
   end

   assign pipe[0] = head_stage;

   for (genvar i = 0; i < udiv_pkg::NUM_STAGES; i++) begin : g_stage
      udiv_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .stage_i (pipe[i]),
         .stage_o (pipe[i+1])
      );
   end

   // Restoring steps already yield an all-ones quotient for a zero divisor;
   // the remainder needs forcing.
   always_comb begin
      quotient_in  = pipe[udiv_pkg::NUM_STAGES].dq;
      remainder_in = pipe[udiv_pkg::NUM_STAGES].div_zero ? '1
                                                         : pipe[udiv_pkg::NUM_STAGES].rem;
      if (pipe[udiv_pkg::NUM_STAGES].div_zero) begin
         quotient_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pipe[udiv_pkg::NUM_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quotient_ff  <= quotient_in;
         remainder_ff <= remainder_in;
         dbz_ff       <= pipe[udiv_pkg::NUM_STAGES].div_zero;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = quotient_ff;
   assign rsp_remainder      = remainder_ff;
   assign rsp_divide_by_zero = dbz_ff;

endmodule

// ===== tb/unsigned_divider_32_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_divider_32_unit_tb
// Self-checking testbench for the pipelined 32-bit unsigned divider.
// Corner cases, then random operand mixes under several sender/receiver
// idle patterns, then a long receiver hold-off that fills the pipeline.
// Every result is compared against a behavioral division in arrival order.
// ----------------------------------------------------------------------------
module unsigned_divider_32_unit_tb;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 40;
   localparam int HOLD_OFF_LEN   = 200;
   localparam udiv_pkg::word_type ALL_ONES = '1;

   typedef struct packed {
      udiv_pkg::word_type quotient;
      udiv_pkg::word_type remainder;
      logic               divide_by_zero;
   } division_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   udiv_pkg::word_type req_dividend;
   udiv_pkg::word_type req_divisor;
   logic               rsp_valid;
   logic               rsp_stall;
   udiv_pkg::word_type rsp_quotient;
   udiv_pkg::word_type rsp_remainder;
   logic               rsp_divide_by_zero;

   division_type expected_divisions[$];
   int           mismatch_count = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           hold_off_left  = 0;
   int           quiet_cycles   = 0;

   unsigned_divider_32_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic division_type compute_division(udiv_pkg::word_type dividend,
                                                     udiv_pkg::word_type divisor);
      division_type res;
      if (divisor == '0) begin
         res.quotient       = ALL_ONES;
         res.remainder      = ALL_ONES;
         res.divide_by_zero = 1'b1;
      end else begin
         res.quotient       = dividend / divisor;
         res.remainder      = dividend % divisor;
         res.divide_by_zero = 1'b0;
      end
      return res;
   endfunction

   // Offer one transaction, with random idle cycles ahead of it; valid stays
   // high after acceptance so back-to-back calls stream without a gap.
   task automatic issue_division(udiv_pkg::word_type dividend, udiv_pkg::word_type divisor);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_dividend <= dividend;
      req_divisor  <= divisor;
      do @(posedge clock); while (req_stall);
      expected_divisions.push_back(compute_division(dividend, divisor));
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (expected_divisions.size() != 0) @(posedge clock);
   endtask

   // Result checker and receiver stall generator
   always @(posedge clock) begin
      division_type exp_res;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_divisions.size() == 0) begin
               $display("%0t: unexpected result q=%h r=%h dbz=%b", $time,
                        rsp_quotient, rsp_remainder, rsp_divide_by_zero);
               mismatch_count++;
            end else begin
               exp_res = expected_divisions.pop_front();
               if (rsp_quotient !== exp_res.quotient) begin
                  $display("%0t: quotient expected %h actual %h", $time,
                           exp_res.quotient, rsp_quotient);
                  mismatch_count++;
               end
               if (rsp_remainder !== exp_res.remainder) begin
                  $display("%0t: remainder expected %h actual %h", $time,
                           exp_res.remainder, rsp_remainder);
                  mismatch_count++;
               end
               if (rsp_divide_by_zero !== exp_res.divide_by_zero) begin
                  $display("%0t: divide_by_zero expected %b actual %b", $time,
                           exp_res.divide_by_zero, rsp_divide_by_zero);
                  mismatch_count++;
               end
            end
         end
         if (hold_off_left > 0) begin
            rsp_stall     <= 1'b1;
            hold_off_left = hold_off_left - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Watchdog: cycles in which neither channel moves a transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic test_directed_corners();
      issue_division(32'h0000_0000, 32'h0000_0000);
      issue_division(32'hFFFF_FFFF, 32'h0000_0000);
      issue_division(32'h0000_0001, 32'h0000_0000);
      issue_division(32'h0000_0000, 32'h0000_0001);
      issue_division(32'hFFFF_FFFF, 32'h0000_0001);
      issue_division(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue_division(32'h0000_0000, 32'hFFFF_FFFF);
      issue_division(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      issue_division(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      issue_division(32'h0000_0005, 32'h0000_0007);
      issue_division(32'h0000_0007, 32'h0000_0007);
      issue_division(32'h8000_0000, 32'h0000_0002);
      issue_division(32'h8000_0000, 32'h8000_0001);
      issue_division(32'h7FFF_FFFF, 32'h8000_0000);
      issue_division(32'hFFFF_FFFF, 32'h0001_0000);
      issue_division(32'hDEAD_BEEF, 32'h0000_0003);
      issue_division(32'h1234_5678, 32'h0000_1234);
      issue_division(32'hAAAA_AAAA, 32'h5555_5555);
      issue_division(32'h5555_5555, 32'hAAAA_AAAA);
      issue_division(32'h0000_0064, 32'h0000_000A);
      wait_all_results();
   endtask

   task automatic test_random_divisions(int n_items, int idle_pct, int stall_pct);
      udiv_pkg::word_type dividend;
      udiv_pkg::word_type divisor;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n_items) begin
         dividend = $urandom;
         divisor  = $urandom;
         case ($urandom_range(9))
            0: divisor = '0;
            1: divisor = divisor >> $urandom_range(31, 16);
            2, 3: begin
               dividend = dividend >> $urandom_range(31, 0);
               divisor  = divisor >> $urandom_range(31, 0);
            end
            4: begin
               // dividend below divisor
               divisor  = divisor | 32'h1;
               dividend = dividend % divisor;
            end
            5: begin
               // exact multiple, product fits without wrap
               divisor  = divisor >> $urandom_range(31, 8);
               dividend = divisor * $urandom_range(255);
            end
            6: divisor = dividend;
            default: ;
         endcase
         issue_division(dividend, divisor);
      end
      wait_all_results();
   endtask

   // Receiver holds off while the sender streams, so the pipeline fills
   // and req_stall must rise.
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_left  = HOLD_OFF_LEN;
      repeat (100) issue_division($urandom, $urandom >> $urandom_range(31, 0));
      wait_all_results();
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_dividend = '0;
      req_divisor  = '0;
      rsp_stall    = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_divisions(330, 0, 0);
      test_random_divisions(330, 54, 0);
      test_random_divisions(330, 0, 54);
      test_random_divisions(330, 30, 30);
      test_output_backpressure();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_divisions.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
